// ----- rtl/utf87_pkg.sv -----
// ============================================================================
// utf87_pkg: shared types and constants of the quoted UTF-7 encoder
// Character codes, the control structs passed between the sequencer, the
// base64 group unit and the output stage.
// ============================================================================
package utf87_pkg;

    // ASCII characters the encoder emits on its own
    localparam logic [6:0] CH_QUOTE = 7'h22;
    localparam logic [6:0] CH_PLUS  = 7'h2b;
    localparam logic [6:0] CH_DASH  = 7'h2d;

    // Width of a decoded unit (five extra bits from four-byte sequences)
    localparam int UNIT_W = 21;

    // Sequencer to base64 group unit
    typedef struct packed {
        logic        load;
        logic        step;
        logic [23:0] data;
    } grp_ctrl_t;

    // Base64 group unit back to sequencer
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } grp_sts_t;

    // Sequencer to output stage
    typedef struct packed {
        logic       emit;
        logic       finish;
        logic [6:0] ch;
    } emit_req_t;

    // Output stage back to sequencer
    typedef struct packed {
        logic emit_ok;
        logic finish_ok;
    } emit_rsp_t;

endpackage

// ----- rtl/utf87_if.sv -----
// ============================================================================
// utf87_if: valid/ready channels of the quoted UTF-7 encoder
// utf87_text_if carries input bytes, utf87_char_if carries output characters.
// ============================================================================
interface utf87_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface utf87_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

// ----- rtl/utf8_to_utf7_quoted_encoder.sv -----
// ============================================================================
// utf8_to_utf7_quoted_encoder: UTF-8 string to double-quoted UTF-7
// Sequencer with decode state; base64 groups go through a shared unit.
// ============================================================================
// Usage:
//   text_in  : one UTF-8 byte per word; a zero byte ends the string.
//   char_out : one ASCII character per word; last_of_run marks the final
//              character caused by the current input byte.
// Each byte is taken only when the sequencer is idle, then worked off one
// step per cycle while char_out does not stall; text_in.ready returns in
// the cycle after the byte is done. A byte goes through dispatch, decode
// and end-of-byte handling plus the emission of each character (a base64
// group is four). A terminator re-decodes up to three pending bytes and
// pads a partial group before the closing quote.
// The newest character waits in a hold slot until the next one or the end
// of the byte, so it reaches char_out one word late; the only character of
// a plain ASCII byte is moved to char_out by the end-of-byte step.
// When char_out stalls, the sequencer stops at the next character and no
// new byte is taken; nothing is dropped.
// Reset puts the block idle with no string open; the next byte starts a
// new string with an opening quote.
// ============================================================================
module utf8_to_utf7_quoted_encoder (
    input  logic         clk,
    input  logic         rst_n,
    utf87_text_if.sink   text_in,
    utf87_char_if.source char_out
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_QUOTE     = 4'd1;
    localparam logic [3:0] ST_DISPATCH  = 4'd2;
    localparam logic [3:0] ST_CHECK     = 4'd3;
    localparam logic [3:0] ST_DRAIN     = 4'd4;
    localparam logic [3:0] ST_UNIT      = 4'd5;
    localparam logic [3:0] ST_DIRECT    = 4'd6;
    localparam logic [3:0] ST_PLUSDASH  = 4'd7;
    localparam logic [3:0] ST_GROUP     = 4'd8;
    localparam logic [3:0] ST_FLUSH_END = 4'd9;
    localparam logic [3:0] ST_CLOSE     = 4'd10;
    localparam logic [3:0] ST_FINISH    = 4'd11;

    localparam int UW = utf87_pkg::UNIT_W;

    logic [3:0]    state_reg;
    logic [3:0]    state_next;
    logic [3:0]    ret_reg;
    logic [3:0]    ret_next;
    logic          started_reg;
    logic          started_next;
    logic          run_reg;
    logic          run_next;
    logic          drain_reg;
    logic          drain_next;
    logic [15:0]   carry_reg;
    logic [15:0]   carry_next;
    logic [1:0]    units_reg;
    logic [1:0]    units_next;
    logic [2:0]    pend_cnt_reg;
    logic [2:0]    pend_cnt_next;
    logic [7:0]    pend_reg [4];
    logic [7:0]    pend_next [4];
    logic [7:0]    byte_reg;
    logic [7:0]    byte_next;
    logic [UW-1:0] unit_reg;
    logic [UW-1:0] unit_next;

    logic [2:0]    lead_len;
    logic [2:0]    drain_len;
    logic [3:0]    done_state;
    logic [23:0]   partial_group;
    logic [15:0]   unit_low;

    utf87_pkg::grp_ctrl_t grp_ctrl;
    utf87_pkg::grp_sts_t  grp_sts;
    utf87_pkg::emit_req_t emit_req;
    utf87_pkg::emit_rsp_t emit_rsp;

    // Sequence length from a lead byte
    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        if (lead <= 8'h7f)
            seq_len = 3'd1;
        else if (lead <= 8'hdf)
            seq_len = 3'd2;
        else if (lead <= 8'hef)
            seq_len = 3'd3;
        else
            seq_len = 3'd4;
    endfunction

    // Decode a sequence without checking continuation bytes
    function automatic logic [UW-1:0] decode(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic [7:0] b3,
                                              input logic [2:0] len);
        case (len)
            3'd2:    decode = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    decode = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    decode = {b0[2:0], b1[5:4], b1[3:0], b2[5:4], b2[3:0], b3[5:0]};
            default: decode = {13'd0, b0};
        endcase
    endfunction

    // Units that pass through unencoded
    function automatic logic is_direct(input logic [UW-1:0] u);
        logic [6:0] c;
        c = u[6:0];
        is_direct = (u < UW'(127)) &&
                    !(c inside {7'h0a, 7'h0d, 7'h5c, 7'h7e, 7'h2b, 7'h3d, 7'h22});
    endfunction

    // Direct characters that need an explicit run close before them
    function automatic logic needs_dash(input logic [6:0] c);
        needs_dash = (c inside {[7'h41:7'h5a], [7'h61:7'h7a], [7'h30:7'h39]}) ||
                     (c == utf87_pkg::CH_PLUS) || (c == 7'h2f) || (c == utf87_pkg::CH_DASH);
    endfunction

    assign text_in.ready = (state_reg == ST_IDLE);
    assign lead_len      = seq_len(pend_reg[0]);
    assign done_state    = drain_reg ? ST_DRAIN : ST_FINISH;
    assign unit_low      = unit_reg[15:0];
    assign partial_group = (units_reg == 2'd2) ? {carry_reg, 8'd0}
                                               : {carry_reg[7:0], 16'd0};

    // Re-decode length for the head of the pending bytes at end of string
    always_comb
    begin
        if (pend_reg[0] <= 8'h7f)
            drain_len = 3'd1;
        else if (pend_reg[0] <= 8'hdf && pend_cnt_reg >= 3'd2)
            drain_len = 3'd2;
        else if (pend_reg[0] <= 8'hef && pend_cnt_reg >= 3'd3)
            drain_len = 3'd3;
        else if (pend_cnt_reg >= 3'd4)
            drain_len = 3'd4;
        else
            drain_len = 3'd1;
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        started_next  = started_reg;
        run_next      = run_reg;
        drain_next    = drain_reg;
        carry_next    = carry_reg;
        units_next    = units_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_next     = pend_reg;
        byte_next     = byte_reg;
        unit_next     = unit_reg;
        grp_ctrl      = '0;
        emit_req      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (text_in.valid)
                begin
                    byte_next  = text_in.text_byte;
                    state_next = started_reg ? ST_DISPATCH : ST_QUOTE;
                end
            end
            ST_QUOTE:
            begin
                emit_req.emit = 1'b1;
                emit_req.ch   = utf87_pkg::CH_QUOTE;
                if (emit_rsp.emit_ok)
                begin
                    started_next = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (byte_reg == 8'd0)
                begin
                    drain_next = 1'b1;
                    state_next = ST_DRAIN;
                end
                else if (pend_cnt_reg == 3'd0 && !byte_reg[7])
                begin
                    unit_next  = {13'd0, byte_reg};
                    state_next = ST_UNIT;
                end
                else
                begin
                    pend_next[pend_cnt_reg[1:0]] = byte_reg;
                    pend_cnt_next = pend_cnt_reg + 3'd1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (pend_cnt_reg >= lead_len)
                begin
                    unit_next     = decode(pend_reg[0], pend_reg[1], pend_reg[2],
                                           pend_reg[3], lead_len);
                    pend_cnt_next = 3'd0;
                    state_next    = ST_UNIT;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_DRAIN:
            begin
                if (pend_cnt_reg == 3'd0)
                    state_next = ST_FLUSH_END;
                else
                begin
                    unit_next     = decode(pend_reg[0], pend_reg[1], pend_reg[2],
                                           pend_reg[3], drain_len);
                    pend_cnt_next = pend_cnt_reg - drain_len;
                    // shift the consumed bytes out of the head
                    case (drain_len)
                        3'd1:
                        begin
                            pend_next[0] = pend_reg[1];
                            pend_next[1] = pend_reg[2];
                            pend_next[2] = pend_reg[3];
                        end
                        3'd2:
                        begin
                            pend_next[0] = pend_reg[2];
                            pend_next[1] = pend_reg[3];
                        end
                        3'd3:
                            pend_next[0] = pend_reg[3];
                        default:
                            pend_next[0] = pend_reg[0];
                    endcase
                    state_next = ST_UNIT;
                end
            end
            ST_UNIT:
            begin
                if (is_direct(unit_reg))
                begin
                    if (units_reg != 2'd0)
                    begin
                        grp_ctrl.load = 1'b1;
                        grp_ctrl.data = partial_group;
                        units_next    = 2'd0;
                        carry_next    = 16'd0;
                        ret_next      = ST_DIRECT;
                        state_next    = ST_GROUP;
                    end
                    else
                        state_next = ST_DIRECT;
                end
                else if (unit_reg == UW'(utf87_pkg::CH_PLUS) && !run_reg)
                begin
                    emit_req.emit = 1'b1;
                    emit_req.ch   = utf87_pkg::CH_PLUS;
                    if (emit_rsp.emit_ok)
                        state_next = ST_PLUSDASH;
                end
                else
                begin
                    case (units_reg)
                        2'd0:
                        begin
                            if (!run_reg)
                            begin
                                emit_req.emit = 1'b1;
                                emit_req.ch   = utf87_pkg::CH_PLUS;
                            end
                            if (run_reg || emit_rsp.emit_ok)
                            begin
                                run_next   = 1'b1;
                                carry_next = unit_low;
                                units_next = 2'd2;
                                state_next = done_state;
                            end
                        end
                        2'd2:
                        begin
                            grp_ctrl.load = 1'b1;
                            grp_ctrl.data = {carry_reg, unit_low[15:8]};
                            carry_next    = {8'd0, unit_low[7:0]};
                            units_next    = 2'd1;
                            ret_next      = done_state;
                            state_next    = ST_GROUP;
                        end
                        default:
                        begin
                            grp_ctrl.load = 1'b1;
                            grp_ctrl.data = {carry_reg[7:0], unit_low};
                            carry_next    = 16'd0;
                            units_next    = 2'd0;
                            ret_next      = done_state;
                            state_next    = ST_GROUP;
                        end
                    endcase
                end
            end
            ST_DIRECT:
            begin
                emit_req.emit = 1'b1;
                if (run_reg && needs_dash(unit_reg[6:0]))
                begin
                    emit_req.ch = utf87_pkg::CH_DASH;
                    if (emit_rsp.emit_ok)
                        run_next = 1'b0;
                end
                else
                begin
                    emit_req.ch = unit_reg[6:0];
                    if (emit_rsp.emit_ok)
                    begin
                        run_next   = 1'b0;
                        state_next = done_state;
                    end
                end
            end
            ST_PLUSDASH:
            begin
                emit_req.emit = 1'b1;
                emit_req.ch   = utf87_pkg::CH_DASH;
                if (emit_rsp.emit_ok)
                    state_next = done_state;
            end
            ST_GROUP:
            begin
                emit_req.emit = 1'b1;
                emit_req.ch   = grp_sts.ch;
                if (emit_rsp.emit_ok)
                begin
                    grp_ctrl.step = 1'b1;
                    if (grp_sts.last)
                        state_next = ret_reg;
                end
            end
            ST_FLUSH_END:
            begin
                if (units_reg != 2'd0)
                begin
                    grp_ctrl.load = 1'b1;
                    grp_ctrl.data = partial_group;
                    units_next    = 2'd0;
                    carry_next    = 16'd0;
                    ret_next      = ST_CLOSE;
                    state_next    = ST_GROUP;
                end
                else
                    state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                emit_req.emit = 1'b1;
                emit_req.ch   = utf87_pkg::CH_QUOTE;
                if (emit_rsp.emit_ok)
                begin
                    started_next  = 1'b0;
                    run_next      = 1'b0;
                    drain_next    = 1'b0;
                    carry_next    = 16'd0;
                    units_next    = 2'd0;
                    pend_cnt_next = 3'd0;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                emit_req.finish = 1'b1;
                if (emit_rsp.finish_ok)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            started_reg  <= 1'b0;
            run_reg      <= 1'b0;
            drain_reg    <= 1'b0;
            carry_reg    <= 16'd0;
            units_reg    <= 2'd0;
            pend_cnt_reg <= 3'd0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            started_reg  <= started_next;
            run_reg      <= run_next;
            drain_reg    <= drain_next;
            carry_reg    <= carry_next;
            units_reg    <= units_next;
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        byte_reg <= byte_next;
        unit_reg <= unit_next;
    end

    utf87_group_unit u_group (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (grp_ctrl),
        .sts   (grp_sts)
    );

    utf87_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (emit_req),
        .rsp      (emit_rsp),
        .char_out (char_out)
    );

    // An accepted byte always starts the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (text_in.valid && text_in.ready) |=> (state_reg != ST_IDLE))
        else $error("sequencer idle after accepting a byte");

    // The closing quote leaves the string state at reset values
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE && emit_rsp.emit_ok) |=>
        (!started_reg && !run_reg && units_reg == 2'd0 && pend_cnt_reg == 3'd0))
        else $error("string state not cleared after closing quote");

    // The fourth base64 character ends the group
    a_group_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GROUP && grp_sts.last && emit_rsp.emit_ok) |=>
        (state_reg != ST_GROUP))
        else $error("group unit emitted more than four characters");

    // Carried bytes exist only inside an open base64 run
    a_carry_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (units_reg != 2'd0) |-> run_reg)
        else $error("carried bytes outside a base64 run");

endmodule

// ----- rtl/utf87_group_unit.sv -----
// ============================================================================
// utf87_group_unit: shared base64 group unit
// Holds one 24-bit group and turns it into four base64 characters, one per
// step, most significant six bits first.
// ============================================================================
module utf87_group_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  utf87_pkg::grp_ctrl_t ctrl,
    output utf87_pkg::grp_sts_t  sts
);

    logic [23:0] data_reg;
    logic [23:0] data_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;

    // 6-bit value to base64 alphabet
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] w;
        w = {1'b0, v};
        if (v < 6'd26)
            b64_char = w + 7'd65;
        else if (v < 6'd52)
            b64_char = w + 7'd71;
        else if (v < 6'd62)
            b64_char = w - 7'd4;
        else if (v == 6'd62)
            b64_char = utf87_pkg::CH_PLUS;
        else
            b64_char = 7'h2f;
    endfunction

    // Load or shift the group
    always_comb
    begin
        data_next = data_reg;
        idx_next  = idx_reg;
        if (ctrl.load)
        begin
            data_next = ctrl.data;
            idx_next  = 2'd0;
        end
        else if (ctrl.step)
        begin
            data_next = {data_reg[17:0], 6'd0};
            idx_next  = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign sts.ch   = b64_char(data_reg[23:18]);
    assign sts.last = (idx_reg == 2'd3);

endmodule

// ----- rtl/utf87_out_stage.sv -----
// ============================================================================
// utf87_out_stage: hold slot and output register
// Keeps the newest character back one slot so that the final character of
// a byte can be flagged when the sequencer signals the end of the byte.
// ============================================================================
module utf87_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  utf87_pkg::emit_req_t req,
    output utf87_pkg::emit_rsp_t rsp,
    utf87_char_if.source         char_out
);

    logic       hold_valid_reg;
    logic       hold_valid_next;
    logic [6:0] hold_char_reg;
    logic [6:0] hold_char_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [6:0] out_char_reg;
    logic [6:0] out_char_next;
    logic       out_last_reg;
    logic       out_last_next;
    logic       out_free;

    assign out_free      = !out_valid_reg || char_out.ready;
    assign rsp.emit_ok   = !hold_valid_reg || out_free;
    assign rsp.finish_ok = !hold_valid_reg || out_free;

    // Move hold slot to output on a new word or at end of byte
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_char_next  = hold_char_reg;
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        if (out_valid_reg && char_out.ready)
            out_valid_next = 1'b0;
        if (req.emit && rsp.emit_ok)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_char_next  = hold_char_reg;
                out_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_char_next  = req.ch;
        end
        else if (req.finish && rsp.finish_ok && hold_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_char_next   = hold_char_reg;
            out_last_next   = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_char_reg <= hold_char_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

    assign char_out.valid       = out_valid_reg;
    assign char_out.out_char    = out_char_reg;
    assign char_out.last_of_run = out_last_reg;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for utf8_to_utf7_quoted_encoder
// Feeds zero-terminated UTF-8 strings one byte per word, predicts every
// quoted UTF-7 character with a behavioral encoder and checks each char_out
// word in order. Both channels idle in random bursts; one long output stall
// backs the encoder up against its input.
// ============================================================================
module testbench;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LONG_HOLD    = 250;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_BYTES = 245;
    localparam int CALM_BYTES   = 50;
    localparam int MAX_REPORTS  = 40;

    // Input bytes with a meaning of their own
    localparam logic [7:0] TERMINATOR = 8'h00;
    localparam logic [7:0] BYTE_LF    = 8'h0a;
    localparam logic [7:0] BYTE_CR    = 8'h0d;
    localparam logic [7:0] BYTE_BSL   = 8'h5c;
    localparam logic [7:0] BYTE_TILDE = 8'h7e;
    localparam logic [7:0] BYTE_EQ    = 8'h3d;
    localparam logic [7:0] BYTE_DEL   = 8'h7f;
    localparam logic [7:0] BYTE_PLUS  = {1'b0, utf87_pkg::CH_PLUS};
    localparam logic [7:0] BYTE_QUOTE = {1'b0, utf87_pkg::CH_QUOTE};
    localparam logic [7:0] BYTE_DASH  = {1'b0, utf87_pkg::CH_DASH};
    localparam logic [6:0] CH_SLASH   = 7'h2f;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } char_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    utf87_text_if text_ch ();
    utf87_char_if char_ch ();

    utf8_to_utf7_quoted_encoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_ch),
        .char_out (char_ch)
    );

    // Encoder state as the predictor sees it
    bit          quote_open = 1'b0;
    logic [7:0]  seq_buf [4];
    int unsigned seq_cnt    = 0;
    bit          run_open   = 1'b0;
    logic [15:0] carry      = '0;
    int unsigned carry_n    = 0;
    char_word_t  step_chars[$];
    char_word_t  expected_chars[$];

    // Stimulus and bookkeeping
    logic [7:0]  text_buf[$];
    bit          idle_enabled  = 1'b1;
    bit          long_hold_req = 1'b0;
    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned bytes_sent    = 0;
    int unsigned strings_done  = 0;
    int unsigned chars_checked = 0;

    // Clock
    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Quoted UTF-7 predictor
    // ------------------------------------------------------------------
    function automatic logic [6:0] b64_letter(input logic [5:0] v);
        if (v < 26) return 7'(8'h41 + v);        // A-Z
        if (v < 52) return 7'(8'h61 + v - 26);   // a-z
        if (v < 62) return 7'(8'h30 + v - 52);   // 0-9
        return (v == 62) ? utf87_pkg::CH_PLUS : CH_SLASH;
    endfunction

    function automatic bit is_b64_letter(input logic [20:0] u);
        return (u >= 21'h41 && u <= 21'h5a) || (u >= 21'h61 && u <= 21'h7a) ||
               (u >= 21'h30 && u <= 21'h39) || u == utf87_pkg::CH_PLUS || u == CH_SLASH;
    endfunction

    function automatic void push_char(input logic [6:0] c);
        char_word_t w;
        w.ch   = c;
        w.last = 1'b0;
        step_chars.push_back(w);
    endfunction

    function automatic void put_group(input logic [23:0] g);
        push_char(b64_letter(g[23:18]));
        push_char(b64_letter(g[17:12]));
        push_char(b64_letter(g[11:6]));
        push_char(b64_letter(g[5:0]));
    endfunction

    // Zero-pad whatever bytes are carried into one last group
    function automatic void flush_group();
        if (carry_n == 2)
            put_group({carry, 8'h00});
        else if (carry_n == 1)
            put_group({carry[7:0], 16'h0000});
        carry   = '0;
        carry_n = 0;
    endfunction

    function automatic void take_unit(input logic [20:0] u);
        logic [15:0] low;
        low = u[15:0];
        if (u < 127 && u != BYTE_LF && u != BYTE_CR && u != BYTE_BSL &&
            u != BYTE_TILDE && u != BYTE_PLUS && u != BYTE_EQ && u != BYTE_QUOTE)
        begin
            // direct character; close an open run first
            flush_group();
            if (run_open)
            begin
                if (is_b64_letter(u) || u == BYTE_DASH)
                    push_char(utf87_pkg::CH_DASH);
                run_open = 1'b0;
            end
            push_char(u[6:0]);
        end
        else if (u == BYTE_PLUS && !run_open)
        begin
            push_char(utf87_pkg::CH_PLUS);
            push_char(utf87_pkg::CH_DASH);
        end
        else if (carry_n == 0)
        begin
            if (!run_open)
            begin
                push_char(utf87_pkg::CH_PLUS);
                run_open = 1'b1;
            end
            carry   = low;
            carry_n = 2;
        end
        else if (carry_n == 2)
        begin
            put_group({carry, low[15:8]});
            carry   = {8'h00, low[7:0]};
            carry_n = 1;
        end
        else
        begin
            put_group({carry[7:0], low});
            carry   = '0;
            carry_n = 0;
        end
    endfunction

    function automatic int seq_length(input logic [7:0] lead);
        if (lead <= 8'h7f) return 1;
        if (lead <= 8'hdf) return 2;
        if (lead <= 8'hef) return 3;
        return 4;
    endfunction

    // Continuation bytes are taken as they come, their top bits ignored
    function automatic logic [20:0] decode_seq(input int first, input int n);
        logic [7:0] b0;
        b0 = seq_buf[first];
        case (n)
            2: return {10'b0, b0[4:0], seq_buf[first + 1][5:0]};
            3: return {5'b0, b0[3:0], seq_buf[first + 1][5:0], seq_buf[first + 2][5:0]};
            4: return {b0[2:0], seq_buf[first + 1][5:4], seq_buf[first + 1][3:0],
                       seq_buf[first + 2][5:4], seq_buf[first + 2][3:0],
                       seq_buf[first + 3][5:0]};
            default: return {13'b0, b0};
        endcase
    endfunction

    // Truncated sequence at the terminator: lead goes out raw, rest re-decoded
    function automatic void drain_seq();
        int unsigned i;
        int unsigned rest;
        logic [7:0]  b;
        i = 0;
        while (i < seq_cnt)
        begin
            b    = seq_buf[i];
            rest = seq_cnt - 1 - i;
            if (b <= 8'h7f)
            begin
                take_unit({13'b0, b});
                i += 1;
            end
            else if (b <= 8'hdf && rest >= 1)
            begin
                take_unit(decode_seq(i, 2));
                i += 2;
            end
            else if (b <= 8'hef && rest >= 2)
            begin
                take_unit(decode_seq(i, 3));
                i += 3;
            end
            else if (rest >= 3)
            begin
                take_unit(decode_seq(i, 4));
                i += 4;
            end
            else
            begin
                take_unit({13'b0, b});
                i += 1;
            end
        end
        seq_cnt = 0;
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        char_word_t w;
        step_chars.delete();
        if (!quote_open)
        begin
            push_char(utf87_pkg::CH_QUOTE);
            quote_open = 1'b1;
        end
        if (b == TERMINATOR)
        begin
            drain_seq();
            flush_group();
            push_char(utf87_pkg::CH_QUOTE);
            quote_open = 1'b0;
            run_open   = 1'b0;
            strings_done++;
        end
        else if (seq_cnt == 0 && b <= 8'h7f)
            take_unit({13'b0, b});
        else
        begin
            seq_buf[seq_cnt & 3] = b;
            seq_cnt = (seq_cnt + 1) & 7;
            if (seq_cnt >= seq_length(seq_buf[0]))
            begin
                take_unit(decode_seq(0, seq_length(seq_buf[0])));
                seq_cnt = 0;
            end
        end
        foreach (step_chars[i])
        begin
            w      = step_chars[i];
            w.last = (i == step_chars.size() - 1);
            expected_chars.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_char(input logic [6:0] ch, input logic last);
        char_word_t want;
        if (expected_chars.size() == 0)
            report_mismatch($sformatf("unexpected char 0x%02h last=%0b", ch, last));
        else
        begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (ch !== want.ch)
                report_mismatch($sformatf("char %0d: out_char 0x%02h, want 0x%02h",
                                          chars_checked, ch, want.ch));
            if (last !== want.last)
                report_mismatch($sformatf("char %0d: last_of_run %0b, want %0b",
                                          chars_checked, last, want.last));
        end
    endtask

    // Both handshakes sampled at the same edge: predict first, then check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_ch.valid === 1'b1 && text_ch.ready === 1'b1)
                predict_byte(text_ch.text_byte);
            if (char_ch.valid === 1'b1 && char_ch.ready === 1'b1)
                check_char(char_ch.out_char, char_ch.last_of_run);
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d chars still expected",
                     cycle_count, expected_chars.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold on request
    initial
    begin
        char_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                char_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
                char_ch.ready <= 1'b1;
            end
            else if (idle_enabled && $urandom_range(0, 5) == 0)
            begin
                char_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                char_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // One word on text_in; valid stays up for a following word
    task automatic send_byte(input logic [7:0] b);
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        @(posedge clk);
        while (text_ch.ready !== 1'b1) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_byte(text_buf[i]);
        text_buf.delete();
    endtask

    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(1, 255));
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    function automatic void append_random_unit();
        int unsigned pick;
        logic [7:0]  c;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            text_buf.push_back(8'($urandom_range(8'h20, 8'h7e)));
        else if (pick < 40)
        begin
            case ($urandom_range(0, 6))
                0: text_buf.push_back(BYTE_LF);
                1: text_buf.push_back(BYTE_CR);
                2: text_buf.push_back(BYTE_BSL);
                3: text_buf.push_back(BYTE_TILDE);
                4: text_buf.push_back(BYTE_PLUS);
                5: text_buf.push_back(BYTE_EQ);
                default: text_buf.push_back(BYTE_QUOTE);
            endcase
        end
        else if (pick < 45)
            text_buf.push_back(($urandom_range(0, 4) == 0) ? BYTE_DEL :
                               8'($urandom_range(1, 31)));
        else if (pick < 60)
        begin
            text_buf.push_back(8'($urandom_range(8'hc2, 8'hdf)));
            text_buf.push_back(cont_byte());
        end
        else if (pick < 75)
        begin
            text_buf.push_back(8'($urandom_range(8'he0, 8'hef)));
            text_buf.push_back(cont_byte());
            text_buf.push_back(cont_byte());
        end
        else if (pick < 85)
        begin
            text_buf.push_back(8'($urandom_range(8'hf0, 8'hff)));
            repeat (3) text_buf.push_back(cont_byte());
        end
        else if (pick < 90)
        begin
            // overlong form of an ASCII value, zero included
            c = 8'($urandom_range(0, 127));
            if ($urandom_range(0, 1) == 0)
            begin
                text_buf.push_back({6'b110000, c[7:6]});
                text_buf.push_back({2'b10, c[5:0]});
            end
            else
            begin
                text_buf.push_back(8'he0);
                text_buf.push_back({6'b100000, c[7:6]});
                text_buf.push_back({2'b10, c[5:0]});
            end
        end
        else
            text_buf.push_back(8'($urandom_range(1, 255)));
    endfunction

    // Well-formed-ish strings; some end in a cut-off sequence
    task automatic send_random_strings(input int unsigned target, input bit vary_idle);
        int unsigned start;
        int unsigned units;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            if (vary_idle)
                idle_enabled = ($urandom_range(0, 3) != 0);
            units = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) :
                                                  $urandom_range(0, 8);
            repeat (units) append_random_unit();
            if ($urandom_range(0, 5) == 0)
            begin
                text_buf.push_back(8'($urandom_range(8'h80, 8'hff)));
                repeat ($urandom_range(0, 2)) text_buf.push_back(cont_byte());
            end
            text_buf.push_back(TERMINATOR);
            send_text();
        end
    endtask

    // Empty string; direct chars, lone plus, escapes, run close with dash
    task automatic test_ascii_and_escapes();
        idle_enabled = 1'b1;
        text_buf = '{TERMINATOR};
        send_text();
        // A + LF a ~ - NUL
        text_buf = '{8'h41, BYTE_PLUS, BYTE_LF, 8'h61, BYTE_TILDE, BYTE_DASH, TERMINATOR};
        send_text();
    endtask

    // Plus inside a run, overlong four-byte form with zero top bits
    task automatic test_base64_runs();
        text_buf = '{BYTE_DEL, BYTE_PLUS, 8'hf0, 8'h80, 8'h81, 8'h81, TERMINATOR};
        send_text();
    endtask

    // Three- and four-byte units, truncated lead re-decoded at the terminator
    task automatic test_multibyte();
        text_buf = '{8'he2, 8'h82, 8'hac, 8'hf0, 8'h9f, 8'h98, 8'h80,
                     8'hff, 8'hc3, 8'ha9, TERMINATOR};
        send_text();
    endtask

    // Output held off for a long stretch while input keeps coming
    task automatic test_output_stall();
        idle_enabled  = 1'b0;
        long_hold_req = 1'b1;
        repeat (12)
        begin
            text_buf.push_back(8'($urandom_range(8'he0, 8'hef)));
            text_buf.push_back(cont_byte());
            text_buf.push_back(cont_byte());
        end
        text_buf.push_back(TERMINATOR);
        send_text();
    endtask

    task automatic test_random_traffic();
        send_random_strings(RANDOM_BYTES, 1'b1);
    endtask

    task automatic test_steady_finish();
        idle_enabled = 1'b0;
        send_random_strings(CALM_BYTES, 1'b0);
    endtask

    // Main sequence
    initial
    begin
        text_ch.valid     <= 1'b0;
        text_ch.text_byte <= 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ascii_and_escapes();
        test_base64_runs();
        test_multibyte();
        test_output_stall();
        test_random_traffic();
        test_steady_finish();
        text_ch.valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Encoded %0d strings from %0d bytes; %0d characters checked",
                 strings_done, bytes_sent, chars_checked);
        $display("Included idle bursts on both sides and a %0d-cycle output stall",
                 LONG_HOLD);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/utf87_pkg.sv
rtl/utf87_if.sv
rtl/utf87_group_unit.sv
rtl/utf87_out_stage.sv
rtl/utf8_to_utf7_quoted_encoder.sv
bench/testbench.sv
